@@ rtl/srfp_pkg.sv @@
package srfp_pkg;

	localparam int MaxSurfaces = 64;
	localparam int IdxW        = 6;
	localparam int CntW        = 8;
	localparam int ActW        = 7;
	localparam int DimW        = 16;
	localparam int CmdW        = 3;
	localparam int StatW       = 3;

	localparam logic [CntW-1:0] CountMax = '1;

	typedef enum logic [CmdW-1:0] {
		CMD_SETUP   = 3'd0,
		CMD_GET     = 3'd1,
		CMD_ADDREF  = 3'd2,
		CMD_RELEASE = 3'd3,
		CMD_CLOSE   = 3'd4
	} cmd_t;

	typedef enum logic [StatW-1:0] {
		STAT_OK        = 3'd0,
		STAT_REUSED    = 3'd1,
		STAT_TOO_MANY  = 3'd2,
		STAT_NONE_FREE = 3'd3,
		STAT_BAD_INDEX = 3'd4,
		STAT_COUNT_ERR = 3'd5,
		STAT_POOL_GONE = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_FILL,
		S_SCAN,
		S_TOUCH,
		S_DONE
	} state_t;

	typedef struct packed {
		status_t         status;
		logic [IdxW-1:0] granted;
		logic            avail;
		logic            retired;
		logic            pool_rel;
	} result_t;

endpackage

@@ rtl/refcounted_surface_pool_core.sv @@
// Reference-counted surface pool.
// Requests enter on req_valid/req_ready with cmd, surface_index, request_count,
// frame_width and frame_height; each request yields exactly one response on
// rsp_valid/rsp_ready carrying status, granted_index and three event flags.
// The block works on one request at a time; the per-surface counts live in a
// 64-entry memory with a registered read port. The steps from acceptance until
// the response is offered:
//   addref and release: decode and read, modify and write, output register.
//   setup rebuild: decode, then request_count counts written, one per cycle.
//   get and close: decode, then scan active surfaces, one entry read per cycle.
//   setup reuse, rejects, unknown commands and a released pool: decode only.
// The next request is accepted in the cycle after the previous result enters
// the output register.
// A new request is taken while the previous response waits in the output
// register; if the receiver stalls longer, the finished result is held inside
// and req_ready stays low until the output register frees.
// Reset restores the pool to one creator reference, no active surfaces, zero
// frame size and every surface count zero; valid bits make this immediate, so
// no clearing pass runs and requests are taken as soon as reset is released.
module refcounted_surface_pool_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [srfp_pkg::CmdW-1:0]     cmd,
	input  logic [srfp_pkg::IdxW-1:0]     surface_index,
	input  logic [srfp_pkg::CntW-1:0]     request_count,
	input  logic [srfp_pkg::DimW-1:0]     frame_width,
	input  logic [srfp_pkg::DimW-1:0]     frame_height,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [srfp_pkg::StatW-1:0]    status,
	output logic [srfp_pkg::IdxW-1:0]     granted_index,
	output logic                          became_available,
	output logic                          surface_retired,
	output logic                          pool_released
);

	logic              res_valid;
	logic              res_ready;
	srfp_pkg::result_t res;
	logic              rsp_valid_q;
	srfp_pkg::result_t rsp_q;

	srfp_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.cmd          (cmd),
		.surface_index(surface_index),
		.request_count(request_count),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign status           = rsp_q.status;
	assign granted_index    = rsp_q.granted;
	assign became_available = rsp_q.avail;
	assign surface_retired  = rsp_q.retired;
	assign pool_released    = rsp_q.pool_rel;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |-> !(res_valid && res_ready))
		else $error("response overwritten while stalled");

	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (granted_index != '0)) |-> (status == srfp_pkg::STAT_OK))
		else $error("granted index set on a failed request");

	a_flags_need_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (became_available || surface_retired || pool_released))
			|-> (status == srfp_pkg::STAT_OK))
		else $error("event flag set on a failed request");

endmodule

@@ rtl/srfp_ram.sv @@
module srfp_ram #(
	parameter int Depth = 64,
	parameter int Width = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/srfp_seq.sv @@
module srfp_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [srfp_pkg::CmdW-1:0]     cmd,
	input  logic [srfp_pkg::IdxW-1:0]     surface_index,
	input  logic [srfp_pkg::CntW-1:0]     request_count,
	input  logic [srfp_pkg::DimW-1:0]     frame_width,
	input  logic [srfp_pkg::DimW-1:0]     frame_height,
	output logic                          res_valid,
	input  logic                          res_ready,
	output srfp_pkg::result_t             res
);

	srfp_pkg::state_t state_q, state_d;

	logic [srfp_pkg::CmdW-1:0] cmd_q;
	logic [srfp_pkg::IdxW-1:0] idx_q;
	logic [srfp_pkg::CntW-1:0] req_q;
	logic [srfp_pkg::DimW-1:0] fw_q;
	logic [srfp_pkg::DimW-1:0] fh_q;

	logic [srfp_pkg::CntW-1:0] pool_q;
	logic [srfp_pkg::ActW-1:0] active_q;
	logic [srfp_pkg::DimW-1:0] width_q;
	logic [srfp_pkg::DimW-1:0] height_q;
	logic [srfp_pkg::ActW-1:0] scan_q;
	logic [srfp_pkg::MaxSurfaces-1:0] valid_q;

	logic                      rd_s1;
	logic                      rd_vld_s1;
	logic [srfp_pkg::IdxW-1:0] rd_idx_s1;

	srfp_pkg::result_t res_q;

	logic                      mem_re;
	logic [srfp_pkg::IdxW-1:0] mem_raddr;
	logic [srfp_pkg::CntW-1:0] mem_rdata;
	logic                      mem_we;
	logic [srfp_pkg::IdxW-1:0] mem_waddr;
	logic [srfp_pkg::CntW-1:0] mem_wdata;

	logic [srfp_pkg::CntW-1:0] cur;
	logic [srfp_pkg::CntW:0]   pool_sum;
	logic is_setup, is_get, is_addref, is_release, is_close;
	logic gone, reuse, too_many, bad_idx, fill_more, scan_more, hit, issue, scan_end;
	logic cur_zero, cur_one, cur_two;

	srfp_ram #(
		.Depth(srfp_pkg::MaxSurfaces),
		.Width(srfp_pkg::CntW)
	) u_counts (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// An entry never written since reset reads as zero.
	assign cur      = rd_vld_s1 ? mem_rdata : '0;
	assign cur_zero = (cur == srfp_pkg::CntW'(0));
	assign cur_one  = (cur == srfp_pkg::CntW'(1));
	assign cur_two  = (cur == srfp_pkg::CntW'(2));

	assign is_setup   = (cmd_q == srfp_pkg::CMD_SETUP);
	assign is_get     = (cmd_q == srfp_pkg::CMD_GET);
	assign is_addref  = (cmd_q == srfp_pkg::CMD_ADDREF);
	assign is_release = (cmd_q == srfp_pkg::CMD_RELEASE);
	assign is_close   = (cmd_q == srfp_pkg::CMD_CLOSE);

	assign gone      = (pool_q == '0);
	assign reuse     = ({1'b0, active_q} >= req_q) && (width_q == fw_q) && (height_q == fh_q);
	assign too_many  = (req_q > srfp_pkg::CntW'(srfp_pkg::MaxSurfaces));
	assign bad_idx   = (srfp_pkg::ActW'(idx_q) >= srfp_pkg::ActW'(srfp_pkg::MaxSurfaces));
	assign fill_more = ({1'b0, scan_q} < req_q);
	assign scan_more = (scan_q < active_q);
	assign hit       = is_get && rd_s1 && cur_one;
	assign issue     = (state_q == srfp_pkg::S_SCAN) && scan_more && !hit;
	assign scan_end  = !scan_more && !rd_s1;
	assign pool_sum  = {1'b0, pool_q} + {1'b0, req_q};

	assign res = res_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			srfp_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = srfp_pkg::S_DECIDE;
				end
			end
			srfp_pkg::S_DECIDE: begin
				if (gone) begin
					state_d = srfp_pkg::S_DONE;
				end else if (is_setup) begin
					state_d = (reuse || too_many) ? srfp_pkg::S_DONE : srfp_pkg::S_FILL;
				end else if (is_get || is_close) begin
					state_d = srfp_pkg::S_SCAN;
				end else if (is_addref || is_release) begin
					state_d = bad_idx ? srfp_pkg::S_DONE : srfp_pkg::S_TOUCH;
				end else begin
					state_d = srfp_pkg::S_DONE;
				end
			end
			srfp_pkg::S_FILL: begin
				if (!fill_more) begin
					state_d = srfp_pkg::S_DONE;
				end
			end
			srfp_pkg::S_SCAN: begin
				if (hit || scan_end) begin
					state_d = srfp_pkg::S_DONE;
				end
			end
			srfp_pkg::S_TOUCH: begin
				state_d = srfp_pkg::S_DONE;
			end
			srfp_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = srfp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = srfp_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = scan_q[srfp_pkg::IdxW-1:0];
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = '0;
		case (state_q)
			srfp_pkg::S_IDLE: begin
				req_ready = 1'b1;
			end
			srfp_pkg::S_DECIDE: begin
				if (!gone && (is_addref || is_release) && !bad_idx) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q;
				end
			end
			srfp_pkg::S_FILL: begin
				if (fill_more) begin
					mem_we    = 1'b1;
					mem_waddr = scan_q[srfp_pkg::IdxW-1:0];
					mem_wdata = srfp_pkg::CntW'(1);
				end
			end
			srfp_pkg::S_SCAN: begin
				mem_re = issue;
				if (hit) begin
					mem_we    = 1'b1;
					mem_wdata = srfp_pkg::CntW'(2);
				end else if (is_close && rd_s1 && !cur_zero) begin
					mem_we    = 1'b1;
					mem_wdata = cur - srfp_pkg::CntW'(1);
				end
			end
			srfp_pkg::S_TOUCH: begin
				if (is_addref && !cur_zero && (cur != srfp_pkg::CountMax)) begin
					mem_we    = 1'b1;
					mem_wdata = cur + srfp_pkg::CntW'(1);
				end else if (is_release && !cur_zero) begin
					mem_we    = 1'b1;
					mem_wdata = cur - srfp_pkg::CntW'(1);
				end
			end
			srfp_pkg::S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= srfp_pkg::S_IDLE;
			pool_q   <= srfp_pkg::CntW'(1);
			active_q <= '0;
			width_q  <= '0;
			height_q <= '0;
			scan_q   <= '0;
			valid_q  <= '0;
			rd_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= mem_re;
			if (mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
			end
			case (state_q)
				srfp_pkg::S_DECIDE: begin
					scan_q <= '0;
					if (!gone && is_setup && !reuse && !too_many) begin
						width_q  <= fw_q;
						height_q <= fh_q;
						active_q <= srfp_pkg::ActW'(req_q);
						pool_q   <= pool_sum[srfp_pkg::CntW] ? srfp_pkg::CountMax
						                                     : pool_sum[srfp_pkg::CntW-1:0];
					end
				end
				srfp_pkg::S_FILL: begin
					if (fill_more) begin
						scan_q <= scan_q + srfp_pkg::ActW'(1);
					end
				end
				srfp_pkg::S_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + srfp_pkg::ActW'(1);
					end
					// A retiring surface and the final creator drop never share a cycle.
					if (is_close && rd_s1 && cur_one && !gone) begin
						pool_q <= pool_q - srfp_pkg::CntW'(1);
					end
					if (is_close && scan_end) begin
						active_q <= '0;
						if (!gone) begin
							pool_q <= pool_q - srfp_pkg::CntW'(1);
						end
					end
				end
				srfp_pkg::S_TOUCH: begin
					if (is_release && cur_one && !gone) begin
						pool_q <= pool_q - srfp_pkg::CntW'(1);
					end
				end
				default: begin
					scan_q <= scan_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q <= cmd;
			idx_q <= surface_index;
			req_q <= request_count;
			fw_q  <= frame_width;
			fh_q  <= frame_height;
		end
		if (mem_re) begin
			rd_idx_s1 <= mem_raddr;
			rd_vld_s1 <= valid_q[mem_raddr];
		end
		case (state_q)
			srfp_pkg::S_DECIDE: begin
				res_q.granted  <= '0;
				res_q.avail    <= 1'b0;
				res_q.retired  <= 1'b0;
				res_q.pool_rel <= 1'b0;
				if (gone) begin
					res_q.status <= srfp_pkg::STAT_POOL_GONE;
				end else if (is_setup && reuse) begin
					res_q.status <= srfp_pkg::STAT_REUSED;
				end else if (is_setup && too_many) begin
					res_q.status <= srfp_pkg::STAT_TOO_MANY;
				end else if (is_get) begin
					res_q.status <= srfp_pkg::STAT_NONE_FREE;
				end else if ((is_addref || is_release) && bad_idx) begin
					res_q.status <= srfp_pkg::STAT_BAD_INDEX;
				end else begin
					res_q.status <= srfp_pkg::STAT_OK;
				end
			end
			srfp_pkg::S_SCAN: begin
				if (hit) begin
					res_q.status  <= srfp_pkg::STAT_OK;
					res_q.granted <= rd_idx_s1;
				end
				if (is_close && rd_s1) begin
					if (cur_two) begin
						res_q.avail <= 1'b1;
					end
					if (cur_one) begin
						res_q.retired <= 1'b1;
						if (pool_q == srfp_pkg::CntW'(1)) begin
							res_q.pool_rel <= 1'b1;
						end
					end
				end
				if (is_close && scan_end && (pool_q == srfp_pkg::CntW'(1))) begin
					res_q.pool_rel <= 1'b1;
				end
			end
			srfp_pkg::S_TOUCH: begin
				if (is_addref && (cur_zero || (cur == srfp_pkg::CountMax))) begin
					res_q.status <= srfp_pkg::STAT_COUNT_ERR;
				end else if (is_release && cur_zero) begin
					res_q.status <= srfp_pkg::STAT_COUNT_ERR;
				end else if (is_release) begin
					res_q.avail    <= cur_two;
					res_q.retired  <= cur_one;
					res_q.pool_rel <= cur_one && (pool_q == srfp_pkg::CntW'(1));
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !rd_s1)
		else $error("read still in flight while taking a new request");

	a_gone_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(pool_q == '0) |=> (pool_q == '0))
		else $error("pool count left zero");

	a_pool_grows_on_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != srfp_pkg::S_DECIDE) |=> (pool_q <= $past(pool_q)))
		else $error("pool count grew outside setup");

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= srfp_pkg::ActW'(srfp_pkg::MaxSurfaces))
		else $error("active count above pool size");

	a_no_write_in_read_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("count entry written and read in the same cycle");

endmodule

@@ verif/srfp_response_checker.sv @@
// Watches both channels of the surface pool, predicts each response from its own copy of the
// pool state and compares responses in order against the predictions.
module srfp_response_checker
	import srfp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  logic [CmdW-1:0] cmd,
	input  logic [IdxW-1:0] surface_index,
	input  logic [CntW-1:0] request_count,
	input  logic [DimW-1:0] frame_width,
	input  logic [DimW-1:0] frame_height,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  logic [StatW-1:0] status,
	input  logic [IdxW-1:0] granted_index,
	input  logic            became_available,
	input  logic            surface_retired,
	input  logic            pool_released,
	output int              errors,
	output int              pending,
	output int              checked
);

	logic [CntW-1:0] surf_refs [MaxSurfaces];
	logic [CntW-1:0] pool_hold;
	logic [ActW-1:0] live_count;
	logic [DimW-1:0] cur_w;
	logic [DimW-1:0] cur_h;
	logic            ev_avail;
	logic            ev_retired;
	logic            ev_pool;
	result_t         expected_rsp [$];
	int              err_total;
	int              match_total;

	function automatic void drop_pool_ref();
		if (pool_hold != '0) begin
			pool_hold = pool_hold - 1'b1;
			if (pool_hold == '0)
				ev_pool = 1'b1;
		end
	endfunction

	// Only called for a surface whose count is nonzero.
	function automatic void release_surface(input int i);
		logic [CntW-1:0] had;
		had = surf_refs[i];
		surf_refs[i] = had - 1'b1;
		if (had == 2) begin
			ev_avail = 1'b1;
		end else if (had == 1) begin
			ev_retired = 1'b1;
			drop_pool_ref();
		end
	endfunction

	function automatic result_t predict_response(input logic [CmdW-1:0] c,
			input logic [IdxW-1:0] idx, input logic [CntW-1:0] n,
			input logic [DimW-1:0] w, input logic [DimW-1:0] h);
		result_t r;
		int      refs;
		int      i;
		logic    found;
		r = '0;
		r.status = STAT_OK;
		found = 1'b0;
		ev_avail = 1'b0;
		ev_retired = 1'b0;
		ev_pool = 1'b0;
		if (pool_hold == '0) begin
			r.status = STAT_POOL_GONE;
		end else begin
			case (c)
				CMD_SETUP: begin
					if (live_count >= n && cur_w == w && cur_h == h) begin
						r.status = STAT_REUSED;
					end else if (n > MaxSurfaces) begin
						r.status = STAT_TOO_MANY;
					end else begin
						cur_w = w;
						cur_h = h;
						live_count = ActW'(n);
						refs = pool_hold;
						for (i = 0; i < n; i++) begin
							surf_refs[i] = 1;
							if (refs < CountMax)
								refs++;
						end
						pool_hold = CntW'(refs);
					end
				end
				CMD_GET: begin
					r.status = STAT_NONE_FREE;
					for (i = 0; i < live_count; i++) begin
						if (!found && surf_refs[i] == 1) begin
							surf_refs[i] = 2;
							r.granted = IdxW'(i);
							r.status = STAT_OK;
							found = 1'b1;
						end
					end
				end
				CMD_ADDREF: begin
					if (idx >= MaxSurfaces)
						r.status = STAT_BAD_INDEX;
					else if (surf_refs[idx] == '0 || surf_refs[idx] == CountMax)
						r.status = STAT_COUNT_ERR;
					else
						surf_refs[idx] = surf_refs[idx] + 1'b1;
				end
				CMD_RELEASE: begin
					if (idx >= MaxSurfaces)
						r.status = STAT_BAD_INDEX;
					else if (surf_refs[idx] == '0)
						r.status = STAT_COUNT_ERR;
					else
						release_surface(idx);
				end
				CMD_CLOSE: begin
					for (i = 0; i < live_count; i++) begin
						if (surf_refs[i] != '0)
							release_surface(i);
					end
					live_count = '0;
					drop_pool_ref();
				end
				default: begin
				end
			endcase
		end
		r.avail = ev_avail;
		r.retired = ev_retired;
		r.pool_rel = ev_pool;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		int      i;
		if (!arst_n) begin
			for (i = 0; i < MaxSurfaces; i++)
				surf_refs[i] = '0;
			pool_hold = 1;
			live_count = '0;
			cur_w = '0;
			cur_h = '0;
			expected_rsp.delete();
			err_total = 0;
			match_total = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				got.status = status_t'(status);
				got.granted = granted_index;
				got.avail = became_available;
				got.retired = surface_retired;
				got.pool_rel = pool_released;
				if (expected_rsp.size() == 0) begin
					err_total++;
					if (err_total <= 10)
						$display("response with no request outstanding: status %0d granted %0d",
							status, granted_index);
				end else begin
					want = expected_rsp.pop_front();
					match_total++;
					if (got.status !== want.status || got.granted !== want.granted ||
							got.avail !== want.avail || got.retired !== want.retired ||
							got.pool_rel !== want.pool_rel) begin
						err_total++;
						if (err_total <= 10) begin
							$write("mismatch on response %0d (expected/actual): status %0d/%0d",
								match_total, want.status, got.status);
							$display(" granted %0d/%0d avail %b/%b retired %b/%b pool %b/%b",
								want.granted, got.granted, want.avail, got.avail,
								want.retired, got.retired, want.pool_rel, got.pool_rel);
						end
					end
				end
			end
			if (req_valid && req_ready)
				expected_rsp.push_back(predict_response(cmd, surface_index, request_count,
					frame_width, frame_height));
			errors <= err_total;
			pending <= expected_rsp.size();
			checked <= match_total;
		end
	end

endmodule

@@ verif/refcounted_surface_pool_core_tb.sv @@
module refcounted_surface_pool_core_tb;
	import srfp_pkg::*;

	localparam int RunLimit    = 1_000_000;
	localparam int DrainCycles = 80;
	localparam int HoldCycles  = 300;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            req_valid = 1'b0;
	logic            rsp_ready = 1'b0;
	logic [CmdW-1:0] cmd = '0;
	logic [IdxW-1:0] surface_index = '0;
	logic [CntW-1:0] request_count = '0;
	logic [DimW-1:0] frame_width = '0;
	logic [DimW-1:0] frame_height = '0;

	logic             req_ready;
	logic             rsp_valid;
	logic [StatW-1:0] status;
	logic [IdxW-1:0]  granted_index;
	logic             became_available;
	logic             surface_retired;
	logic             pool_released;

	int   errors;
	int   pending;
	int   checked;
	int   items_sent = 0;
	int   cycles = 0;
	int   cmd_tally [8];
	logic hold_off = 1'b0;
	logic [1:0] phase = 2'd0;

	logic [DimW-1:0] size_w [4] = '{16'd1920, 16'd1280, 16'd720, 16'd3840};
	logic [DimW-1:0] size_h [4] = '{16'd1080, 16'd720, 16'd576, 16'd2160};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	refcounted_surface_pool_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_ready        (req_ready),
		.cmd              (cmd),
		.surface_index    (surface_index),
		.request_count    (request_count),
		.frame_width      (frame_width),
		.frame_height     (frame_height),
		.rsp_valid        (rsp_valid),
		.rsp_ready        (rsp_ready),
		.status           (status),
		.granted_index    (granted_index),
		.became_available (became_available),
		.surface_retired  (surface_retired),
		.pool_released    (pool_released)
	);

	srfp_response_checker u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_ready        (req_ready),
		.cmd              (cmd),
		.surface_index    (surface_index),
		.request_count    (request_count),
		.frame_width      (frame_width),
		.frame_height     (frame_height),
		.rsp_valid        (rsp_valid),
		.rsp_ready        (rsp_ready),
		.status           (status),
		.granted_index    (granted_index),
		.became_available (became_available),
		.surface_retired  (surface_retired),
		.pool_released    (pool_released),
		.errors           (errors),
		.pending          (pending),
		.checked          (checked)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RunLimit) begin
			$display("refcounted_surface_pool_core_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || hold_off)
			rsp_ready <= 1'b0;
		else if (phase == 2'd0)
			rsp_ready <= ($urandom_range(99) >= 49);
		else if (phase == 2'd1)
			rsp_ready <= ($urandom_range(99) >= 21);
		else
			rsp_ready <= 1'b1;
	end

	// Long receiver stall while requests keep coming, so the block backs up and drops req_ready.
	initial begin
		wait (items_sent >= 120);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic send_req(input logic [CmdW-1:0] c, input logic [IdxW-1:0] idx,
			input logic [CntW-1:0] n, input logic [DimW-1:0] w, input logic [DimW-1:0] h);
		int gap_pct;
		gap_pct = (items_sent < 350) ? 21 : (items_sent < 700) ? 49 : 0;
		phase <= (items_sent < 350) ? 2'd0 : (items_sent < 700) ? 2'd1 : 2'd2;
		if ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		req_valid <= 1'b1;
		cmd <= c;
		surface_index <= idx;
		request_count <= n;
		frame_width <= w;
		frame_height <= h;
		do @(posedge clk); while (!req_ready);
		items_sent++;
		cmd_tally[c]++;
	endtask

	// Mostly small pools so that gets and closes scan few entries.
	function automatic logic [CntW-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return CntW'($urandom_range(8, 1));
		else if (r < 82)
			return CntW'($urandom_range(MaxSurfaces, 9));
		else if (r < 90)
			return '0;
		else
			return CntW'($urandom_range(255, MaxSurfaces + 1));
	endfunction

	// A few common frame sizes make the reuse path likely; the rest are arbitrary.
	function automatic logic [2*DimW-1:0] pick_frame();
		int k;
		k = $urandom_range(9);
		if (k < 8)
			return {size_w[k % 4], size_h[k % 4]};
		else
			return {DimW'($urandom), DimW'($urandom)};
	endfunction

	function automatic logic [IdxW-1:0] pick_index(input int span);
		if ($urandom_range(99) < 80 && span > 0)
			return IdxW'($urandom_range(span - 1, 0));
		else
			return IdxW'($urandom_range(MaxSurfaces - 1, 0));
	endfunction

	initial begin : stimulus
		int              k;
		int              ops;
		int              pick;
		int              span;
		logic            storm_done;
		logic [CntW-1:0] n;
		logic [IdxW-1:0] idx;
		logic [DimW-1:0] w;
		logic [DimW-1:0] h;

		span = 1;
		storm_done = 1'b0;
		for (k = 0; k < 8; k++)
			cmd_tally[k] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: empty pool, rejects, a full rebuild, the count transitions and close.
		send_req(CMD_SETUP, '0, '0, '0, '0);
		send_req(CMD_GET, '0, '0, '0, '0);
		send_req(CMD_ADDREF, '0, '0, '0, '0);
		send_req(CMD_RELEASE, '1, '0, '0, '0);
		send_req(CMD_SETUP, '0, CntW'(MaxSurfaces + 1), 16'd1920, 16'd1080);
		send_req(CMD_SETUP, '1, '1, '1, '1);
		send_req(CMD_SETUP, '0, CntW'(MaxSurfaces), '1, '1);
		send_req(CMD_SETUP, '0, CntW'(MaxSurfaces), '1, '1);
		send_req(CMD_SETUP, '0, CntW'(3), '1, '1);
		send_req(CMD_GET, '0, '0, '0, '0);
		send_req(CMD_GET, '0, '0, '0, '0);
		send_req(CMD_ADDREF, IdxW'(1), '0, '0, '0);
		send_req(CMD_RELEASE, IdxW'(1), '0, '0, '0);
		send_req(CMD_RELEASE, IdxW'(1), '0, '0, '0);
		send_req(CMD_RELEASE, IdxW'(1), '0, '0, '0);
		send_req(CMD_RELEASE, IdxW'(1), '0, '0, '0);
		send_req(CMD_ADDREF, IdxW'(2), '0, '0, '0);
		send_req(CMD_CLOSE, '0, '0, '0, '0);
		send_req(CMD_GET, '0, '0, '0, '0);
		send_req(CMD_RELEASE, '0, '0, '0, '0);
		send_req(CmdW'(5), '1, '1, '1, '1);
		send_req(CmdW'(7), '0, '0, '0, '0);
		send_req(CMD_ADDREF, IdxW'(2), '0, '0, '0);

		// Random episodes: a setup, then a mostly get/addref/release burst, sometimes a close.
		while (items_sent < 760) begin
			if (!storm_done && items_sent >= 480) begin
				// Drive one surface's count to saturation and past it.
				storm_done = 1'b1;
				send_req(CMD_SETUP, '0, CntW'(MaxSurfaces), 16'hA5A5, 16'h5A5A);
				idx = IdxW'($urandom_range(MaxSurfaces - 1, 0));
				repeat (256) send_req(CMD_ADDREF, idx, CntW'($urandom), DimW'($urandom),
					DimW'($urandom));
				send_req(CMD_RELEASE, idx, '0, '0, '0);
				send_req(CMD_RELEASE, idx, '0, '0, '0);
			end
			{w, h} = pick_frame();
			n = pick_count();
			send_req(CMD_SETUP, IdxW'($urandom), n, w, h);
			if (n != '0 && n <= MaxSurfaces)
				span = n;
			ops = $urandom_range(20, 4);
			for (k = 0; k < ops; k++) begin
				pick = $urandom_range(99);
				if (pick < 33) begin
					send_req(CMD_GET, IdxW'($urandom), CntW'($urandom), DimW'($urandom),
						DimW'($urandom));
				end else if (pick < 48) begin
					send_req(CMD_ADDREF, pick_index(span), CntW'($urandom), DimW'($urandom),
						DimW'($urandom));
				end else if (pick < 83) begin
					send_req(CMD_RELEASE, pick_index(span), CntW'($urandom), DimW'($urandom),
						DimW'($urandom));
				end else if (pick < 90) begin
					{w, h} = pick_frame();
					n = pick_count();
					send_req(CMD_SETUP, IdxW'($urandom), n, w, h);
				end else if (pick < 94) begin
					send_req(CMD_CLOSE, IdxW'($urandom), CntW'($urandom), DimW'($urandom),
						DimW'($urandom));
				end else begin
					send_req(CmdW'($urandom_range(7, 5)), IdxW'($urandom), CntW'($urandom),
						DimW'($urandom), DimW'($urandom));
				end
			end
			if ($urandom_range(4) == 0)
				send_req(CMD_CLOSE, '0, '0, '0, '0);
		end

		// The pool holds at most 255 references, so this many closes is sure to release it.
		repeat (256) send_req(CMD_CLOSE, IdxW'($urandom), CntW'($urandom), DimW'($urandom),
			DimW'($urandom));
		repeat (8) send_req(CmdW'($urandom_range(7, 0)), IdxW'($urandom), CntW'($urandom),
			DimW'($urandom), DimW'($urandom));
		req_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("%0d requests (setup %0d, get %0d, addref %0d, release %0d, close %0d, other %0d)",
			items_sent, cmd_tally[CMD_SETUP], cmd_tally[CMD_GET], cmd_tally[CMD_ADDREF],
			cmd_tally[CMD_RELEASE], cmd_tally[CMD_CLOSE],
			cmd_tally[5] + cmd_tally[6] + cmd_tally[7]);
		$display("%0d responses checked over count saturation, a long stall and pool teardown",
			checked);
		if (errors == 0)
			$display("refcounted_surface_pool_core_tb: done, clean");
		else
			$display("refcounted_surface_pool_core_tb: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/srfp_pkg.sv
rtl/srfp_ram.sv
rtl/srfp_seq.sv
rtl/refcounted_surface_pool_core.sv
verif/srfp_response_checker.sv
verif/refcounted_surface_pool_core_tb.sv
